>>> rtl/dlr_pkg.sv
`timescale 1ns / 1ps

package dlr_pkg;

  // Sequencer states of the rasterizer
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_EMIT
  } dlr_state_t;

  // Item codes on the mode field
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

endpackage

>>> rtl/dlr_div.sv
`timescale 1ns / 1ps

module dlr_div #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [COORD_BITS+FRAC_BITS:0]   dividend,
  input  logic [COORD_BITS-1:0]           divisor,
  output logic                            done,
  output logic [FRAC_BITS:0]              quotient
);

  localparam int NumW = COORD_BITS + FRAC_BITS + 1;
  localparam int CntW = $clog2(NumW + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CntW-1:0]       cnt_r;
  logic [NumW-1:0]       num_r;
  logic [COORD_BITS-1:0] rem_r;
  logic [COORD_BITS-1:0] div_r;
  logic [FRAC_BITS:0]    quot_r;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, num_r[NumW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(NumW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[NumW-2:0], 1'b0};
      rem_r  <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quot_r <= {quot_r[FRAC_BITS-1:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

>>> rtl/dda_line_rasterizer.sv
// DDA line rasterizer. A load transfer (mode 0) takes two endpoints, sets the
// step count to the larger of |dx| and |dy|, and derives per-axis increments
// with FRAC_BITS fraction bits, rounded to nearest; the start pixel comes out
// as step 0. Each advance transfer (mode 1) adds the increments and returns
// the position rounded half up, with last_pixel marking the endpoint; once
// the line is done, advances return pixel_valid = 0 with all fields zero.
// A zero-length line returns its start pixel marked last. The increments
// come from one bit-serial restoring divider used once per axis. An
// advance steps the accumulators first and then, once the output slot is
// free, loads the output register. A finished result sits in the output
// register while the next transfer is taken in.
`timescale 1ns / 1ps

module dda_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_pixel_valid,
  output logic                  out_last_pixel,
  output logic [COORD_BITS-1:0] out_step_number
);

  import dlr_pkg::*;

  localparam int AccW = COORD_BITS + FRAC_BITS + 1;
  localparam int StpW = FRAC_BITS + 2;
  localparam int NumW = COORD_BITS + FRAC_BITS + 1;
  localparam logic signed [StpW-1:0] StepOne = {2'b01, {FRAC_BITS{1'b0}}};

  dlr_state_t state_r, state_nxt;

  logic signed [AccW-1:0] x_accum_r, y_accum_r;
  logic signed [StpW-1:0] x_step_r, y_step_r;
  logic [COORD_BITS-1:0]  step_count_r, total_steps_r;
  logic                   line_active_r;
  logic                   x_neg_r, y_neg_r;
  logic [COORD_BITS-1:0]  ady_r;
  logic                   emit_valid_r, emit_last_r;

  logic                   out_valid_r;
  logic [COORD_BITS-1:0]  out_pixel_x_r, out_pixel_y_r, out_step_number_r;
  logic                   out_pixel_valid_r, out_last_pixel_r;

  // Load decode
  logic [COORD_BITS:0]    dx, dy;
  logic [COORD_BITS:0]    ax_full, ay_full;
  logic [COORD_BITS-1:0]  ax, ay, steps_in;
  logic                   in_xfer, load_xfer, adv_xfer;
  logic                   slot_free, out_load, div_start;

  // Divider operands
  logic [COORD_BITS-1:0]  div_mag, div_steps;
  logic [NumW-1:0]        dividend;
  logic                   div_done;
  logic [FRAC_BITS:0]     div_quot;
  logic signed [StpW-1:0] quot_ext, step_nxt;

  logic [COORD_BITS-1:0]  count_inc;
  logic [COORD_BITS-1:0]  round_x, round_y;

  function automatic logic [COORD_BITS-1:0] round_pos(input logic [AccW-1:0] acc);
    logic [AccW:0] v;
    v = {acc[AccW-1], acc} + ((AccW+1)'(1) << (FRAC_BITS - 1));
    if (v[AccW]) begin
      round_pos = '0;
    end else if (v[AccW-1]) begin
      round_pos = '1;
    end else begin
      round_pos = v[AccW-2:FRAC_BITS];
    end
  endfunction

  assign dx       = {1'b0, in_end_x} - {1'b0, in_start_x};
  assign dy       = {1'b0, in_end_y} - {1'b0, in_start_y};
  assign ax_full  = dx[COORD_BITS] ? -dx : dx;
  assign ay_full  = dy[COORD_BITS] ? -dy : dy;
  assign ax       = ax_full[COORD_BITS-1:0];
  assign ay       = ay_full[COORD_BITS-1:0];
  assign steps_in = (ax > ay) ? ax : ay;

  assign in_xfer   = in_valid && in_ready;
  assign load_xfer = in_xfer && (in_mode == MODE_LOAD);
  assign adv_xfer  = in_xfer && (in_mode == MODE_ADVANCE);
  assign slot_free = !out_valid_r || out_ready;

  // x division starts from the live inputs, y from what the load left behind
  assign div_mag   = (state_r == S_IDLE) ? ax : ady_r;
  assign div_steps = (state_r == S_IDLE) ? steps_in : total_steps_r;
  assign dividend  = {1'b0, div_mag, {FRAC_BITS{1'b0}}} + NumW'(div_steps >> 1);

  dlr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (div_steps),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign quot_ext = {1'b0, div_quot};
  assign step_nxt = ((state_r == S_DIVX) ? x_neg_r : y_neg_r) ? -quot_ext : quot_ext;

  assign count_inc = step_count_r + 1'b1;
  assign round_x   = round_pos(x_accum_r);
  assign round_y   = round_pos(y_accum_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (load_xfer) begin
          state_nxt = (steps_in == '0) ? S_EMIT : S_DIVX;
        end else if (adv_xfer) begin
          state_nxt = S_EMIT;
        end
      end
      S_DIVX: begin
        if (div_done) state_nxt = S_DIVY;
      end
      S_DIVY: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && (in_mode == MODE_LOAD) && (steps_in != '0);
      end
      S_DIVX:  div_start = div_done;
      S_DIVY:  div_start = 1'b0;
      S_EMIT:  out_load  = slot_free;
      default: in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_xfer) begin
        line_active_r <= steps_in != '0;
      end else if (adv_xfer && line_active_r && (count_inc >= total_steps_r)) begin
        line_active_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_xfer) begin
      x_accum_r     <= {1'b0, in_start_x, {FRAC_BITS{1'b0}}};
      y_accum_r     <= {1'b0, in_start_y, {FRAC_BITS{1'b0}}};
      x_step_r      <= '0;
      y_step_r      <= '0;
      step_count_r  <= '0;
      total_steps_r <= steps_in;
      x_neg_r       <= dx[COORD_BITS];
      y_neg_r       <= dy[COORD_BITS];
      ady_r         <= ay;
      emit_valid_r  <= 1'b1;
      emit_last_r   <= steps_in == '0;
    end else if (adv_xfer) begin
      if (line_active_r) begin
        step_count_r <= count_inc;
        x_accum_r    <= x_accum_r + AccW'(x_step_r);
        y_accum_r    <= y_accum_r + AccW'(y_step_r);
        emit_valid_r <= 1'b1;
        emit_last_r  <= count_inc >= total_steps_r;
      end else begin
        emit_valid_r <= 1'b0;
        emit_last_r  <= 1'b0;
      end
    end else if (div_done) begin
      if (state_r == S_DIVX) begin
        x_step_r <= step_nxt;
      end else begin
        y_step_r <= step_nxt;
      end
    end
  end

  // Output register; an invalid result carries all-zero fields
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_x_r     <= emit_valid_r ? round_x : '0;
      out_pixel_y_r     <= emit_valid_r ? round_y : '0;
      out_step_number_r <= emit_valid_r ? step_count_r : '0;
      out_pixel_valid_r <= emit_valid_r;
      out_last_pixel_r  <= emit_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_pixel_valid = out_pixel_valid_r;
  assign out_last_pixel  = out_last_pixel_r;
  assign out_step_number = out_step_number_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside a division state");

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    line_active_r |-> (total_steps_r != '0) && (step_count_r < total_steps_r))
    else $error("active line with step count at or past its end");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (line_active_r && state_r == S_IDLE) |->
      (x_step_r <= StepOne) && (x_step_r >= -StepOne) &&
      (y_step_r <= StepOne) && (y_step_r >= -StepOne))
    else $error("increment magnitude above one pixel");

endmodule
